FILE: design/awi_pkg.sv
package awi_pkg;

  // sizes of the index spaces
  localparam int unsigned MAX_TEXELS      = 216;
  localparam int unsigned MAX_GRID_POINTS = 64;
  localparam int unsigned TEXEL_IDX_W     = $clog2(MAX_TEXELS);
  localparam int unsigned GRID_IDX_W      = $clog2(MAX_GRID_POINTS);

  // fixed-point layout of an axis position
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned SCALE_W = 11;
  localparam int unsigned SHARE_W = 5;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned SLOTS   = 4;

  // rounding terms
  localparam int unsigned POS_ROUND   = 32;
  localparam int unsigned POS_SHIFT   = 6;
  localparam int unsigned SHARE_ROUND = 8;
  localparam int unsigned SHARE_ONE   = 16;

  // configuration register map
  typedef enum logic [2:0] {
    REG_VOLUME_MODE  = 3'd0,
    REG_BLOCK_WIDTH  = 3'd1,
    REG_BLOCK_HEIGHT = 3'd2,
    REG_BLOCK_DEPTH  = 3'd3,
    REG_GRID_WIDTH   = 3'd4,
    REG_GRID_HEIGHT  = 3'd5,
    REG_GRID_DEPTH   = 3'd6
  } cfg_reg_e;

  // one texel request
  typedef struct packed {
    logic [3:0] texel_x;
    logic [3:0] texel_y;
    logic [2:0] texel_z;
  } texel_req_t;

  // one infill result
  typedef struct packed {
    logic [TEXEL_IDX_W-1:0] texel_index;
    logic [COUNT_W-1:0]     contrib_count;
    logic [GRID_IDX_W-1:0]  grid_index0;
    logic [GRID_IDX_W-1:0]  grid_index1;
    logic [GRID_IDX_W-1:0]  grid_index2;
    logic [GRID_IDX_W-1:0]  grid_index3;
    logic [SHARE_W-1:0]     share0;
    logic [SHARE_W-1:0]     share1;
    logic [SHARE_W-1:0]     share2;
    logic [SHARE_W-1:0]     share3;
  } infill_rsp_t;

  // (1024 + b/2) / (b-1), zero for blocks narrower than two texels
  function automatic logic [SCALE_W-1:0] axis_scale(logic [3:0] bdim);
    logic [SCALE_W-1:0] s;
    unique case (bdim)
      4'd2:    s = 11'd1025;
      4'd3:    s = 11'd512;
      4'd4:    s = 11'd342;
      4'd5:    s = 11'd256;
      4'd6:    s = 11'd205;
      4'd7:    s = 11'd171;
      4'd8:    s = 11'd146;
      4'd9:    s = 11'd128;
      4'd10:   s = 11'd114;
      4'd11:   s = 11'd102;
      4'd12:   s = 11'd93;
      4'd13:   s = 11'd85;
      4'd14:   s = 11'd79;
      4'd15:   s = 11'd73;
      default: s = '0;
    endcase
    return s;
  endfunction

  // grid size minus one, an empty grid counts as one point
  function automatic logic [3:0] axis_span(logic [3:0] gdim);
    return (gdim == 4'd0) ? 4'd0 : gdim - 4'd1;
  endfunction

endpackage

FILE: design/astc_weight_infill_texel_core.sv
// Weight-grid infill for one texel per clock. A request carries a texel
// position; the result gives the linear texel index and up to four weight-grid
// points with their weights in sixteenths, nonzero weights packed from slot 0.
// Plane mode uses rounded bilinear weights, volume mode simplex weights.
// The datapath is a four-stage pipeline (scale product, axis position, corner
// weights, slot packing) whose last stage loads the output register, and a
// new request is taken every cycle; the whole pipe holds only while the output
// register is full and not taken. Configuration goes through the APB port with
// one register per word, and must only change while no request is in flight.
module astc_weight_infill_texel_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // texel requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  awi_pkg::texel_req_t  in_req_i,
  // infill results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output awi_pkg::infill_rsp_t out_rsp_o
);
  import awi_pkg::*;

  localparam int unsigned PROD_W = SCALE_W + 4;
  localparam int unsigned SUM_W  = PROD_W + 4;

  // configuration registers
  logic       volume_mode_q;
  logic [3:0] block_width_q, block_height_q, grid_width_q, grid_height_q;
  logic [2:0] block_depth_q, grid_depth_q;
  cfg_reg_e   cfg_sel;
  logic       cfg_write;

  assign cfg_sel   = cfg_reg_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_mode_q  <= 1'b0;
      block_width_q  <= 4'd4;
      block_height_q <= 4'd4;
      block_depth_q  <= 3'd2;
      grid_width_q   <= 4'd4;
      grid_height_q  <= 4'd4;
      grid_depth_q   <= 3'd1;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_VOLUME_MODE:  volume_mode_q  <= pwdata[0];
        REG_BLOCK_WIDTH:  block_width_q  <= pwdata[3:0];
        REG_BLOCK_HEIGHT: block_height_q <= pwdata[3:0];
        REG_BLOCK_DEPTH:  block_depth_q  <= pwdata[2:0];
        REG_GRID_WIDTH:   grid_width_q   <= pwdata[3:0];
        REG_GRID_HEIGHT:  grid_height_q  <= pwdata[3:0];
        REG_GRID_DEPTH:   grid_depth_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_VOLUME_MODE:  prdata[0]   = volume_mode_q;
      REG_BLOCK_WIDTH:  prdata[3:0] = block_width_q;
      REG_BLOCK_HEIGHT: prdata[3:0] = block_height_q;
      REG_BLOCK_DEPTH:  prdata[2:0] = block_depth_q;
      REG_GRID_WIDTH:   prdata[3:0] = grid_width_q;
      REG_GRID_HEIGHT:  prdata[3:0] = grid_height_q;
      REG_GRID_DEPTH:   prdata[2:0] = grid_depth_q;
      default: ;
    endcase
  end

  // pipeline advance: everything moves unless the output register is stuck
  logic adv;
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // stage 1: scale times coordinate per axis, partial texel row
  logic [PROD_W-1:0] s1_prod_x_d, s1_prod_y_d, s1_prod_z_d;
  logic [PROD_W-1:0] s1_prod_x_q, s1_prod_y_q, s1_prod_z_q;
  logic [7:0]        s1_row_d, s1_row_q;
  logic [3:0]        s1_x_q;

  always_comb begin
    s1_prod_x_d = PROD_W'(axis_scale(block_width_q)) * PROD_W'(in_req_i.texel_x);
    s1_prod_y_d = PROD_W'(axis_scale(block_height_q)) * PROD_W'(in_req_i.texel_y);
    s1_prod_z_d = PROD_W'(axis_scale({1'b0, block_depth_q})) * PROD_W'(in_req_i.texel_z);
    if (volume_mode_q) begin
      s1_row_d = 8'(in_req_i.texel_z) * 8'(block_height_q) + 8'(in_req_i.texel_y);
    end else begin
      s1_row_d = 8'(in_req_i.texel_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_x_q <= s1_prod_x_d;
      s1_prod_y_q <= s1_prod_y_d;
      s1_prod_z_q <= s1_prod_z_d;
      s1_row_q    <= s1_row_d;
      s1_x_q      <= in_req_i.texel_x;
    end
  end

  // stage 2: rounded axis positions, split into cell and fraction
  logic [SUM_W-1:0]        s2_sum_x, s2_sum_y, s2_sum_z;
  logic [FRAC_W-1:0]       s2_fx_q, s2_fy_q, s2_fz_q;
  logic [GRID_IDX_W-1:0]   s2_ix_q, s2_iy_q, s2_iz_q;
  logic [TEXEL_IDX_W-1:0]  s2_texel_d, s2_texel_q;

  always_comb begin
    s2_sum_x = s1_prod_x_q * axis_span(grid_width_q) + SUM_W'(POS_ROUND);
    s2_sum_y = s1_prod_y_q * axis_span(grid_height_q) + SUM_W'(POS_ROUND);
    s2_sum_z = s1_prod_z_q * axis_span({1'b0, grid_depth_q}) + SUM_W'(POS_ROUND);
    s2_texel_d = TEXEL_IDX_W'(s1_row_q * block_width_q) + TEXEL_IDX_W'(s1_x_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_fx_q    <= s2_sum_x[POS_SHIFT +: FRAC_W];
      s2_fy_q    <= s2_sum_y[POS_SHIFT +: FRAC_W];
      s2_fz_q    <= s2_sum_z[POS_SHIFT +: FRAC_W];
      s2_ix_q    <= s2_sum_x[POS_SHIFT+FRAC_W +: GRID_IDX_W];
      s2_iy_q    <= s2_sum_y[POS_SHIFT+FRAC_W +: GRID_IDX_W];
      s2_iz_q    <= s2_sum_z[POS_SHIFT+FRAC_W +: GRID_IDX_W];
      s2_texel_q <= s2_texel_d;
    end
  end

  // stage 3: candidate grid points and their weights
  logic [GRID_IDX_W-1:0]  s3_cand_d [SLOTS];
  logic [SHARE_W-1:0]     s3_wt_d   [SLOTS];
  logic [GRID_IDX_W-1:0]  s3_cand_q [SLOTS];
  logic [SHARE_W-1:0]     s3_wt_q   [SLOTS];
  logic [TEXEL_IDX_W-1:0] s3_texel_q;

  always_comb begin
    logic [7:0]            fxy;
    logic [SHARE_W-1:0]    w3;
    logic [GRID_IDX_W-1:0] row, plane, step1, step2, base;
    logic [FRAC_W-1:0]     a, b, c;

    fxy   = 8'(s2_fx_q) * 8'(s2_fy_q);
    w3    = SHARE_W'((9'(fxy) + 9'(SHARE_ROUND)) >> FRAC_W);
    row   = GRID_IDX_W'(grid_width_q);
    plane = GRID_IDX_W'(grid_width_q) * GRID_IDX_W'(grid_height_q);
    step1 = '0;
    step2 = '0;
    a     = '0;
    b     = '0;
    c     = '0;
    if (!volume_mode_q) begin
      // bilinear corners of one cell
      base = s2_ix_q + GRID_IDX_W'(s2_iy_q * grid_width_q);
      s3_cand_d[0] = base;
      s3_cand_d[1] = base + GRID_IDX_W'(1);
      s3_cand_d[2] = base + row;
      s3_cand_d[3] = base + row + GRID_IDX_W'(1);
      s3_wt_d[3]   = w3;
      s3_wt_d[1]   = SHARE_W'(s2_fx_q) - w3;
      s3_wt_d[2]   = SHARE_W'(s2_fy_q) - w3;
      s3_wt_d[0]   = SHARE_W'(SHARE_ONE) - SHARE_W'(s2_fx_q) - SHARE_W'(s2_fy_q) + w3;
    end else begin
      // simplex chosen by the ordering of the three fractions
      base = GRID_IDX_W'((s2_iz_q * grid_height_q + GRID_IDX_W'(s2_iy_q))
                         * grid_width_q) + s2_ix_q;
      priority if (s2_fx_q > s2_fy_q && s2_fy_q > s2_fz_q) begin
        step1 = GRID_IDX_W'(1); step2 = row;
        a = s2_fx_q; b = s2_fy_q; c = s2_fz_q;
      end else if (s2_fy_q >= s2_fx_q && s2_fx_q > s2_fz_q) begin
        step1 = row; step2 = GRID_IDX_W'(1);
        a = s2_fy_q; b = s2_fx_q; c = s2_fz_q;
      end else if (s2_fx_q > s2_fz_q && s2_fz_q >= s2_fy_q) begin
        step1 = GRID_IDX_W'(1); step2 = plane;
        a = s2_fx_q; b = s2_fz_q; c = s2_fy_q;
      end else if (s2_fz_q >= s2_fx_q && s2_fx_q > s2_fy_q) begin
        step1 = plane; step2 = GRID_IDX_W'(1);
        a = s2_fz_q; b = s2_fx_q; c = s2_fy_q;
      end else if (s2_fy_q > s2_fz_q && s2_fz_q >= s2_fx_q) begin
        step1 = row; step2 = plane;
        a = s2_fy_q; b = s2_fz_q; c = s2_fx_q;
      end else begin
        step1 = plane; step2 = row;
        a = s2_fz_q; b = s2_fy_q; c = s2_fx_q;
      end
      s3_cand_d[0] = base;
      s3_cand_d[1] = base + step1;
      s3_cand_d[2] = base + step1 + step2;
      s3_cand_d[3] = base + GRID_IDX_W'(1) + row + plane;
      s3_wt_d[0]   = SHARE_W'(SHARE_ONE) - SHARE_W'(a);
      s3_wt_d[1]   = SHARE_W'(a) - SHARE_W'(b);
      s3_wt_d[2]   = SHARE_W'(b) - SHARE_W'(c);
      s3_wt_d[3]   = SHARE_W'(c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_cand_q  <= s3_cand_d;
      s3_wt_q    <= s3_wt_d;
      s3_texel_q <= s2_texel_q;
    end
  end

  // stage 4: drop zero weights and pack the rest from slot 0
  infill_rsp_t out_rsp_d, out_rsp_q;

  always_comb begin
    logic [GRID_IDX_W-1:0] idx [SLOTS];
    logic [SHARE_W-1:0]    shr [SLOTS];
    logic [COUNT_W-1:0]    cnt;

    cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      idx[i] = '0;
      shr[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (s3_wt_q[i] != '0) begin
        idx[cnt[1:0]] = s3_cand_q[i];
        shr[cnt[1:0]] = s3_wt_q[i];
        cnt = cnt + COUNT_W'(1);
      end
    end
    out_rsp_d.texel_index   = s3_texel_q;
    out_rsp_d.contrib_count = cnt;
    out_rsp_d.grid_index0   = idx[0];
    out_rsp_d.grid_index1   = idx[1];
    out_rsp_d.grid_index2   = idx[2];
    out_rsp_d.grid_index3   = idx[3];
    out_rsp_d.share0        = shr[0];
    out_rsp_d.share1        = shr[1];
    out_rsp_d.share2        = shr[2];
    out_rsp_d.share3        = shr[3];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_rsp_o = out_rsp_q;

endmodule
